// ===== rtl/psqe_pkg.sv =====
// psqe_pkg: shared types and constants for the polyline stroke quad expander
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package psqe_pkg;

    // default coordinate format, signed Q15.8
    localparam int COORD_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 8;

    // operand width of the shared multiplier
    localparam int MUL_W = 30;

    // configuration register indexes
    localparam logic REG_LINE_WIDTH   = 1'b0;
    localparam logic REG_STROKE_COLOR = 1'b1;

    // configuration reset values
    localparam logic [15:0] LINE_WIDTH_RST   = 16'd256;
    localparam logic [31:0] STROKE_COLOR_RST = 32'hFFFF_FFFF;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_SQX,
        ST_SQY,
        ST_SUM,
        ST_SQRT,
        ST_DIVX,
        ST_DIVY,
        ST_SCX,
        ST_SCY,
        ST_SCST,
        ST_CORN
    } psqe_state_t;

endpackage
`default_nettype wire

// ===== rtl/psqe_mul.sv =====
// psqe_mul: shared unsigned multiplier with registered product
// depends on psqe_pkg
`timescale 1ns / 1ps
`default_nettype none
module psqe_mul (
    input  wire logic                              aclk,
    input  wire logic [psqe_pkg::MUL_W-1:0]        op_a,
    input  wire logic [psqe_pkg::MUL_W-1:0]        op_b,
    output logic      [2*psqe_pkg::MUL_W-1:0]      prod
);
    import psqe_pkg::*;

    logic [2*MUL_W-1:0] prod_reg;

    // one multiply per cycle, product registered for the next cycle
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

// ===== rtl/polyline_stroke_quad_expander.sv =====
// polyline_stroke_quad_expander: top level, sequencer and iterative datapath
// depends on psqe_pkg and psqe_mul
//
// Usage: path points enter on the s_ channel (valid/ready). A point with
// s_path_start set, or the first point after reset, is only stored. Every
// other point closes a segment and yields one transaction on the m_ channel:
// the four stroke quad corners, the vertex base index and the colour.
// Configuration: cfg_we with cfg_addr 0 = line width (Q8.8), 1 = colour.
// Per segment the sequencer steps through accept, normalize (one shift per
// step, plus a final check), square and sum, bit-serial square root, two
// bit-serial divides, scale and corner; most of the time goes to the
// bit-serial square root and divider. One multiplier serves the squares
// and the scaling. A zero-length segment goes straight to the corner state.
// Path start points are only stored.
// The next point is taken only once the sequencer is idle again; a result
// waiting in the output register does not block the next point's work, only
// the corner cycle of the next segment waits until the receiver takes it.
// Reset (aresetn low, synchronous) clears the stored point, the vertex count,
// the output valid and restores line width 1.0 and colour all ones.
`timescale 1ns / 1ps
`default_nettype none
module polyline_stroke_quad_expander #(
    parameter int COORD_BITS = psqe_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = psqe_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // configuration
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_addr,
    input  wire logic [31:0]                  cfg_wdata,
    // point input
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [COORD_BITS-1:0] s_point_x,
    input  wire logic signed [COORD_BITS-1:0] s_point_y,
    input  wire logic                         s_path_start,
    // quad output
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [COORD_BITS-1:0]      m_corner0_x,
    output logic signed [COORD_BITS-1:0]      m_corner0_y,
    output logic signed [COORD_BITS-1:0]      m_corner1_x,
    output logic signed [COORD_BITS-1:0]      m_corner1_y,
    output logic signed [COORD_BITS-1:0]      m_corner2_x,
    output logic signed [COORD_BITS-1:0]      m_corner2_y,
    output logic signed [COORD_BITS-1:0]      m_corner3_x,
    output logic signed [COORD_BITS-1:0]      m_corner3_y,
    output logic [31:0]                       m_base_index,
    output logic [31:0]                       m_vertex_color
);
    import psqe_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int NW  = (C + 1 > 31) ? C + 1 : 31;       // normalize register
    localparam int MW  = 34 + FRAC_BITS;                  // scaled product
    localparam int RW  = MW - 25;                         // offset magnitude
    localparam int OW  = RW + 1;                          // signed offset
    localparam int SW  = ((C > OW) ? C : OW) + 1;         // corner sum

    // configuration registers
    logic [15:0] line_width_reg;
    logic [31:0] stroke_color_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= LINE_WIDTH_RST;
            stroke_color_reg <= STROKE_COLOR_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_LINE_WIDTH:   line_width_reg   <= cfg_wdata[15:0];
                REG_STROKE_COLOR: stroke_color_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // state and datapath registers
    psqe_state_t state_reg, state_next;
    logic          have_prev_reg, have_prev_next;
    logic [C-1:0]  prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic [C-1:0]  cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic          neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;
    logic [NW-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic [61:0]   sum_reg, sum_next;
    logic [61:0]   sq_n_reg, sq_n_next, sq_root_reg, sq_root_next, sq_bit_reg, sq_bit_next;
    logic [31:0]   rem_reg, rem_next;
    logic [16:0]   quo_reg, quo_next, qx_reg, qx_next;
    logic [4:0]    dcnt_reg, dcnt_next;
    logic [OW-1:0] ox_reg, ox_next, oy_reg, oy_next;
    logic [31:0]   vcount_reg, vcount_next;
    logic          m_valid_reg, m_valid_next;
    logic [C-1:0]  c0x_reg, c0x_next, c0y_reg, c0y_next, c1x_reg, c1x_next, c1y_reg, c1y_next;
    logic [C-1:0]  c2x_reg, c2x_next, c2y_reg, c2y_next, c3x_reg, c3x_next, c3y_reg, c3y_next;
    logic [31:0]   base_reg, base_next, color_reg, color_next;

    // shared multiplier
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [2*MUL_W-1:0] prod;

    psqe_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // saturate a corner sum to the coordinate range
    function automatic logic [C-1:0] sat_coord(input logic [SW-1:0] v);
        logic [C-1:0] r;
        if (v[SW-1:C-1] == {(SW-C+1){1'b0}} || v[SW-1:C-1] == {(SW-C+1){1'b1}}) begin
            r = v[C-1:0];
        end else if (v[SW-1]) begin
            r = {1'b1, {(C-1){1'b0}}};
        end else begin
            r = {1'b0, {(C-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic [SW-1:0] ext_c(input logic [C-1:0] v);
        return {{(SW-C){v[C-1]}}, v};
    endfunction

    function automatic logic [SW-1:0] ext_o(input logic [OW-1:0] v);
        return {{(SW-OW){v[OW-1]}}, v};
    endfunction

    // rounded, signed offset from a scale product
    function automatic logic [OW-1:0] round_off(input logic [32:0] p, input logic neg);
        logic [MW-1:0] m;
        logic [OW-1:0] r;
        m = ({{(MW-33){1'b0}}, p} << FRAC_BITS) + (MW'(1) << 24);
        r = {1'b0, m[MW-1:25]};
        return neg ? (~r + OW'(1)) : r;
    endfunction

    // combinational helpers
    logic [C:0]    dx, dy, adx, ady;
    logic [NW-1:0] a_or;
    logic [61:0]   sq_trial;
    logic [31:0]   rem_sh;
    logic [31:0]   len32;
    logic          dbit;
    logic [NW-1:0] div_src;

    assign s_ready = (state_reg == ST_IDLE);
    assign a_or    = ax_reg | ay_reg;
    assign sq_trial = sq_root_reg + sq_bit_reg;
    assign len32   = {1'b0, sq_root_reg[30:0]};
    assign div_src = (state_reg == ST_DIVX) ? ax_reg : ay_reg;
    assign dbit    = (dcnt_reg == 5'd16) ? div_src[0] : 1'b0;
    assign rem_sh  = {rem_reg[30:0], dbit};

    always_comb begin
        dx  = {s_point_x[C-1], s_point_x} - {prev_x_reg[C-1], prev_x_reg};
        dy  = {s_point_y[C-1], s_point_y} - {prev_y_reg[C-1], prev_y_reg};
        adx = dx[C] ? (~dx + (C+1)'(1)) : dx;
        ady = dy[C] ? (~dy + (C+1)'(1)) : dy;
    end

    // sequencer and datapath next state
    always_comb begin
        state_next     = state_reg;
        have_prev_next = have_prev_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        neg_x_next     = neg_x_reg;
        neg_y_next     = neg_y_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        sum_next       = sum_reg;
        sq_n_next      = sq_n_reg;
        sq_root_next   = sq_root_reg;
        sq_bit_next    = sq_bit_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        qx_next        = qx_reg;
        dcnt_next      = dcnt_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        vcount_next    = vcount_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        c0x_next = c0x_reg; c0y_next = c0y_reg; c1x_next = c1x_reg; c1y_next = c1y_reg;
        c2x_next = c2x_reg; c2y_next = c2y_reg; c3x_next = c3x_reg; c3y_next = c3y_reg;
        base_next      = base_reg;
        color_next     = color_reg;
        mul_a          = ax_reg[MUL_W-1:0];
        mul_b          = ax_reg[MUL_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_path_start || !have_prev_reg) begin
                        prev_x_next    = s_point_x;
                        prev_y_next    = s_point_y;
                        have_prev_next = 1'b1;
                    end else begin
                        cur_x_next = s_point_x;
                        cur_y_next = s_point_y;
                        neg_x_next = dx[C];
                        neg_y_next = dy[C];
                        ax_next    = NW'(adx);
                        ay_next    = NW'(ady);
                        ox_next    = '0;
                        oy_next    = '0;
                        state_next = (adx == '0 && ady == '0) ? ST_CORN : ST_NORM;
                    end
                end
            end
            // one shift a cycle until the larger magnitude is in [2^29, 2^30)
            ST_NORM: begin
                if (a_or[NW-1:30] != '0) begin
                    ax_next = ax_reg >> 1;
                    ay_next = ay_reg >> 1;
                end else if (!a_or[29]) begin
                    ax_next = ax_reg << 1;
                    ay_next = ay_reg << 1;
                end else begin
                    state_next = ST_SQX;
                end
            end
            ST_SQX: begin
                state_next = ST_SQY;
            end
            ST_SQY: begin
                mul_a      = ay_reg[MUL_W-1:0];
                mul_b      = ay_reg[MUL_W-1:0];
                sum_next   = {2'b0, prod};
                state_next = ST_SUM;
            end
            ST_SUM: begin
                sq_n_next    = sum_reg + {2'b0, prod};
                sq_root_next = '0;
                sq_bit_next  = 62'(1) << 60;
                state_next   = ST_SQRT;
            end
            // one root bit a cycle
            ST_SQRT: begin
                if (sq_n_reg >= sq_trial) begin
                    sq_n_next    = sq_n_reg - sq_trial;
                    sq_root_next = (sq_root_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_root_next = sq_root_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
                if (sq_bit_reg[0]) begin
                    rem_next   = {2'b0, ax_reg[30:1]};
                    quo_next   = '0;
                    dcnt_next  = 5'd16;
                    state_next = ST_DIVX;
                end
            end
            // one quotient bit a cycle, shared for both axes
            ST_DIVX, ST_DIVY: begin
                if (rem_sh >= len32) begin
                    rem_next = rem_sh - len32;
                    quo_next = {quo_reg[15:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[15:0], 1'b0};
                end
                dcnt_next = dcnt_reg - 5'd1;
                if (dcnt_reg == 5'd0) begin
                    if (state_reg == ST_DIVX) begin
                        qx_next    = quo_next;
                        rem_next   = {2'b0, ay_reg[30:1]};
                        quo_next   = '0;
                        dcnt_next  = 5'd16;
                        state_next = ST_DIVY;
                    end else begin
                        state_next = ST_SCX;
                    end
                end
            end
            ST_SCX: begin
                mul_a      = MUL_W'(qx_reg);
                mul_b      = MUL_W'(line_width_reg);
                state_next = ST_SCY;
            end
            ST_SCY: begin
                mul_a      = MUL_W'(quo_reg);
                mul_b      = MUL_W'(line_width_reg);
                ox_next    = round_off(prod[32:0], neg_x_reg);
                state_next = ST_SCST;
            end
            ST_SCST: begin
                oy_next    = round_off(prod[32:0], neg_y_reg);
                state_next = ST_CORN;
            end
            // corners into the output register once it is free
            ST_CORN: begin
                if (!m_valid_reg || m_ready) begin
                    c0x_next = sat_coord(ext_c(prev_x_reg) + ext_o(oy_reg));
                    c0y_next = sat_coord(ext_c(prev_y_reg) - ext_o(ox_reg));
                    c1x_next = sat_coord(ext_c(cur_x_reg) + ext_o(oy_reg));
                    c1y_next = sat_coord(ext_c(cur_y_reg) - ext_o(ox_reg));
                    c2x_next = sat_coord(ext_c(cur_x_reg) - ext_o(oy_reg));
                    c2y_next = sat_coord(ext_c(cur_y_reg) + ext_o(ox_reg));
                    c3x_next = sat_coord(ext_c(prev_x_reg) - ext_o(oy_reg));
                    c3y_next = sat_coord(ext_c(prev_y_reg) + ext_o(ox_reg));
                    base_next    = vcount_reg;
                    color_next   = stroke_color_reg;
                    vcount_next  = vcount_reg + 32'd4;
                    m_valid_next = 1'b1;
                    prev_x_next  = cur_x_reg;
                    prev_y_next  = cur_y_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            have_prev_reg <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            vcount_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            have_prev_reg <= have_prev_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            vcount_reg    <= vcount_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        neg_x_reg   <= neg_x_next;
        neg_y_reg   <= neg_y_next;
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        sum_reg     <= sum_next;
        sq_n_reg    <= sq_n_next;
        sq_root_reg <= sq_root_next;
        sq_bit_reg  <= sq_bit_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        qx_reg      <= qx_next;
        dcnt_reg    <= dcnt_next;
        ox_reg      <= ox_next;
        oy_reg      <= oy_next;
        c0x_reg <= c0x_next; c0y_reg <= c0y_next; c1x_reg <= c1x_next; c1y_reg <= c1y_next;
        c2x_reg <= c2x_next; c2y_reg <= c2y_next; c3x_reg <= c3x_next; c3y_reg <= c3y_next;
        base_reg    <= base_next;
        color_reg   <= color_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_corner0_x    = c0x_reg;
    assign m_corner0_y    = c0y_reg;
    assign m_corner1_x    = c1x_reg;
    assign m_corner1_y    = c1y_reg;
    assign m_corner2_x    = c2x_reg;
    assign m_corner2_y    = c2y_reg;
    assign m_corner3_x    = c3x_reg;
    assign m_corner3_y    = c3y_reg;
    assign m_base_index   = base_reg;
    assign m_vertex_color = color_reg;

endmodule
`default_nettype wire
